### rtl/mce_pkg.sv
`timescale 1ns / 1ps

package mce_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        SYM_DOT  = 2'd0,
        SYM_DASH = 2'd1,
        SYM_LGAP = 2'd2,
        SYM_WGAP = 2'd3
    } t_sym;

    typedef enum logic [1:0] {
        MODE_CODE,
        MODE_GAPS,
        MODE_WORD
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    localparam int unsigned CODE_MAX = 8;
    localparam int unsigned GAP_RUN  = 3;

    // Left-aligned pattern: bit 7 is the first symbol, 1 = dash.
    typedef struct packed {
        logic       hit;
        logic [3:0] len;
        logic [7:0] pat;
    } t_code;

    typedef struct packed {
        logic load;
        logic advance;
    } t_cmd_bus;

    typedef struct packed {
        logic empty;
        logic last;
    } t_sts_bus;

    function automatic t_code code_lookup(input logic [7:0] c);
        logic [7:0] u;
        t_code      r;
        u = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
        r = '{hit: 1'b1, len: 4'd0, pat: 8'b0};
        unique case (u)
            8'h41: begin r.len = 4'd2; r.pat = 8'b01000000; end
            8'h42: begin r.len = 4'd4; r.pat = 8'b10000000; end
            8'h43: begin r.len = 4'd4; r.pat = 8'b10100000; end
            8'h44: begin r.len = 4'd3; r.pat = 8'b10000000; end
            8'h45: begin r.len = 4'd1; r.pat = 8'b00000000; end
            8'h46: begin r.len = 4'd4; r.pat = 8'b00100000; end
            8'h47: begin r.len = 4'd3; r.pat = 8'b11000000; end
            8'h48: begin r.len = 4'd4; r.pat = 8'b00000000; end
            8'h49: begin r.len = 4'd2; r.pat = 8'b00000000; end
            8'h4A: begin r.len = 4'd4; r.pat = 8'b01110000; end
            8'h4B: begin r.len = 4'd3; r.pat = 8'b10100000; end
            8'h4C: begin r.len = 4'd4; r.pat = 8'b01000000; end
            8'h4D: begin r.len = 4'd2; r.pat = 8'b11000000; end
            8'h4E: begin r.len = 4'd2; r.pat = 8'b10000000; end
            8'h4F: begin r.len = 4'd3; r.pat = 8'b11100000; end
            8'h50: begin r.len = 4'd4; r.pat = 8'b01100000; end
            8'h51: begin r.len = 4'd4; r.pat = 8'b11010000; end
            8'h52: begin r.len = 4'd3; r.pat = 8'b01000000; end
            8'h53: begin r.len = 4'd3; r.pat = 8'b00000000; end
            8'h54: begin r.len = 4'd1; r.pat = 8'b10000000; end
            8'h55: begin r.len = 4'd3; r.pat = 8'b00100000; end
            8'h56: begin r.len = 4'd4; r.pat = 8'b00010000; end
            8'h57: begin r.len = 4'd3; r.pat = 8'b01100000; end
            8'h58: begin r.len = 4'd4; r.pat = 8'b10010000; end
            8'h59: begin r.len = 4'd4; r.pat = 8'b10110000; end
            8'h5A: begin r.len = 4'd4; r.pat = 8'b11000000; end
            8'h30: begin r.len = 4'd5; r.pat = 8'b11111000; end
            8'h31: begin r.len = 4'd5; r.pat = 8'b01111000; end
            8'h32: begin r.len = 4'd5; r.pat = 8'b00111000; end
            8'h33: begin r.len = 4'd5; r.pat = 8'b00011000; end
            8'h34: begin r.len = 4'd5; r.pat = 8'b00001000; end
            8'h35: begin r.len = 4'd5; r.pat = 8'b00000000; end
            8'h36: begin r.len = 4'd5; r.pat = 8'b10000000; end
            8'h37: begin r.len = 4'd5; r.pat = 8'b11000000; end
            8'h38: begin r.len = 4'd5; r.pat = 8'b11100000; end
            8'h39: begin r.len = 4'd5; r.pat = 8'b11110000; end
            8'h21: begin r.len = 4'd6; r.pat = 8'b11001100; end
            8'h3F: begin r.len = 4'd6; r.pat = 8'b00110000; end
            8'h2F: begin r.len = 4'd5; r.pat = 8'b10010000; end
            8'h3D: begin r.len = 4'd5; r.pat = 8'b10001000; end
            8'h23: begin r.len = 4'd4; r.pat = 8'b11110000; end
            8'h25: begin r.len = 4'd5; r.pat = 8'b01010000; end
            8'h7C: begin r.len = 4'd5; r.pat = 8'b10110000; end
            8'h24: begin r.len = 4'd6; r.pat = 8'b11110100; end
            8'h26: begin r.len = 4'd8; r.pat = 8'b10100100; end
            8'h5E: begin r.len = 4'd4; r.pat = 8'b00110000; end
            8'h2A: begin r.len = 4'd4; r.pat = 8'b01010000; end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/mce_datapath.sv
`timescale 1ns / 1ps

module mce_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mce_pkg::t_cmd_bus i_cmd,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_char_code,
    output mce_pkg::t_sts_bus o_sts,
    output logic [1:0]        o_symbol
);
    import mce_pkg::*;

    logic [7:0] r_pat, n_pat;
    logic [3:0] r_len, n_len;
    logic [3:0] r_idx, n_idx;
    t_mode      r_mode, n_mode;
    t_code      w_code;
    logic       w_last;
    logic       w_empty;

    assign w_code = code_lookup(i_char_code);

    always_comb begin
        n_pat     = r_pat;
        n_len     = r_len;
        n_idx     = r_idx;
        n_mode    = r_mode;
        w_empty   = 1'b0;
        if (i_cmd.load) begin
            n_idx = 4'd0;
            n_pat = w_code.pat;
            n_len = w_code.len;
            unique case (t_cmd'(i_command))
                CMD_START, CMD_END: n_mode = MODE_GAPS;
                CMD_CHAR: begin
                    if ((i_char_code == 8'h20) || (i_char_code == 8'h0A)) begin
                        n_mode = MODE_WORD;
                    end else begin
                        n_mode  = MODE_CODE;
                        w_empty = !w_code.hit;
                    end
                end
                default: begin
                    n_mode  = MODE_WORD;
                    w_empty = 1'b1;
                end
            endcase
        end else if (i_cmd.advance) begin
            n_idx = r_idx + 4'd1;
            n_pat = {r_pat[6:0], 1'b0};
        end
    end

    always_comb begin
        unique case (r_mode)
            MODE_CODE: begin
                w_last   = (r_idx == r_len);
                o_symbol = w_last ? SYM_LGAP : (r_pat[7] ? SYM_DASH : SYM_DOT);
            end
            MODE_GAPS: begin
                w_last   = (r_idx == 4'(GAP_RUN - 1));
                o_symbol = SYM_LGAP;
            end
            default: begin
                w_last   = 1'b1;
                o_symbol = SYM_WGAP;
            end
        endcase
    end

    assign o_sts = '{empty: w_empty, last: w_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 4'd0;
            r_mode <= MODE_WORD;
        end else begin
            r_idx  <= n_idx;
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
        r_len <= n_len;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_CODE) |-> (r_idx <= r_len) && (r_len <= 4'(CODE_MAX)))
        else $error("symbol index ran past code length");

    a_gap_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_GAPS) |-> (r_idx < 4'(GAP_RUN)))
        else $error("gap run too long");

    a_word_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_WORD) |-> (r_idx == 4'd0))
        else $error("word gap advanced");

endmodule

### rtl/mce_ctrl.sv
`timescale 1ns / 1ps

module mce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  mce_pkg::t_sts_bus i_sts,
    output mce_pkg::t_cmd_bus o_cmd
);
    import mce_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.advance = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.empty) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### rtl/morse_code_encoder_core.sv
`timescale 1ns / 1ps

// Morse encoder: each listed request (start, character, end) yields a burst of
// symbols on the output channel, one per cycle while i_ready is high, with
// o_last on the final one. A character request is loaded, then sends its
// code plus a letter gap (at most 9 symbols); start and end send 3 letter
// gaps, space/newline one word gap; an unlisted byte is taken but sends none.
// The rate is set by the single symbol shift register in the datapath; a new
// request is taken only after the last symbol of the previous one is taken.
module morse_code_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_symbol,
    output logic       o_last
);
    import mce_pkg::*;

    t_cmd_bus w_cmd;
    t_sts_bus w_sts;

    mce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    mce_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .o_sts       (w_sts),
        .o_symbol    (o_symbol)
    );

    assign o_last = w_sts.last;

endmodule
